/* rtl/core/bbs_pkg.sv */
// shared types and constants for the brian's brain stencil step unit
package bbs_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int GRID_WIDTH_RESET  = 384;
  localparam int GRID_HEIGHT_RESET = 216;

  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 9;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [1:0] CELL_DEAD  = 2'd0;
  localparam logic [1:0] CELL_DYING = 2'd1;
  localparam logic [1:0] CELL_ALIVE = 2'd2;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic [1:0] next_state;
    logic       last_of_frame;
  } out_t;

endpackage

/* rtl/core/brians_brain_stencil_step_unit.sv */
// Pipeline: the cell transfer that completes a result loads the input stage, which feeds the output register.
// Throughput: one cell per clock, held back only while the output register waits on result_ready.
// The first width+1 cells of a frame give no result; each later cell gives the next cell's result.
// The two line buffers are single-write memories with registered reads, one read and one write per cell.
// Reset (synchronous) restores the grid size, empties the pipeline and restarts the frame;
// line buffer contents are not cleared.
module brians_brain_stencil_step_unit #(
  parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cell_valid,
  output logic                            cell_ready,
  input  bbs_pkg::in_t                    cell_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output bbs_pkg::out_t                   result,
  input  logic                            cfg_write,
  input  logic [bbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RST = (bbs_pkg::GRID_WIDTH_RESET > MAX_WIDTH) ?
                         MAX_WIDTH : bbs_pkg::GRID_WIDTH_RESET;
  localparam int H_RST = (bbs_pkg::GRID_HEIGHT_RESET > MAX_HEIGHT) ?
                         MAX_HEIGHT : bbs_pkg::GRID_HEIGHT_RESET;
  localparam logic [3:0] BIRTH_COUNT = 4'd2;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < 3) r = 3;
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [WW-1:0]  width_eff;
  logic [HW-1:0]  height_eff;

  logic [1:0]     upper_line  [MAX_WIDTH];
  logic [1:0]     middle_line [MAX_WIDTH];

  logic [IRW-1:0] in_row;
  logic [CW-1:0]  in_col;

  logic           a_valid;
  logic           a_res;
  logic [CW-1:0]  a_col;
  logic [1:0]     a_x;
  logic [1:0]     a_top;
  logic [1:0]     a_mid;

  // window columns that become left and centre when the next column arrives
  logic [1:0]     col_a [3];
  logic [1:0]     col_b [3];

  logic [ORW-1:0] out_row;
  logic [CW-1:0]  out_col;

  logic           accept;
  logic           b_go;
  logic [1:0]     x_in;
  logic           beat_res;
  logic           beat_last;
  logic           col_wrap;
  logic           out_wrap;
  logic           last_b;
  logic           lm, rm, tm, bm;
  logic [1:0]     right [3];
  logic [3:0]     n_alive;
  logic [1:0]     state_next;

  assign accept     = cell_valid && cell_ready;
  assign b_go       = a_valid && (!a_res || !result_valid || result_ready);
  assign cell_ready = !a_valid || b_go;
  assign x_in       = cell_data.flush ? bbs_pkg::CELL_DEAD : cell_data.cell_state;

  assign beat_res  = (in_row >= IRW'(2)) || ((in_row == IRW'(1)) && (in_col != '0));
  // the cell at row height+1, column 0 completes the frame's final result
  assign beat_last = (in_row == (IRW'(height_eff) + IRW'(1))) && (in_col == '0);
  assign col_wrap  = (WW'(in_col) + WW'(1)) >= width_eff;

  assign out_wrap = (WW'(out_col) + WW'(1)) >= width_eff;
  assign last_b   = ((HW'(out_row) + HW'(1)) >= height_eff) && out_wrap;

  assign lm = out_col != '0;
  assign rm = !out_wrap;
  assign tm = out_row != '0;
  assign bm = (HW'(out_row) + HW'(1)) < height_eff;

  assign right[0] = a_top;
  assign right[1] = a_mid;
  assign right[2] = a_x;

  always_comb begin
    n_alive = 4'(lm && tm && (col_a[0] == bbs_pkg::CELL_ALIVE))
            + 4'(tm && (col_b[0] == bbs_pkg::CELL_ALIVE))
            + 4'(rm && tm && (right[0] == bbs_pkg::CELL_ALIVE))
            + 4'(lm && (col_a[1] == bbs_pkg::CELL_ALIVE))
            + 4'(rm && (right[1] == bbs_pkg::CELL_ALIVE))
            + 4'(lm && bm && (col_a[2] == bbs_pkg::CELL_ALIVE))
            + 4'(bm && (col_b[2] == bbs_pkg::CELL_ALIVE))
            + 4'(rm && bm && (right[2] == bbs_pkg::CELL_ALIVE));
    case (col_b[1])
      bbs_pkg::CELL_ALIVE: state_next = bbs_pkg::CELL_DYING;
      bbs_pkg::CELL_DYING: state_next = bbs_pkg::CELL_DEAD;
      bbs_pkg::CELL_DEAD:  state_next = (n_alive == BIRTH_COUNT) ?
                                        bbs_pkg::CELL_ALIVE : bbs_pkg::CELL_DEAD;
      default:             state_next = bbs_pkg::CELL_DEAD;
    endcase
  end

  // line buffers: middle written on transfer, upper when the cell leaves the input stage
  always_ff @(posedge clk) begin
    if (accept) begin
      a_mid <= middle_line[in_col];
      middle_line[in_col] <= x_in;
      a_x   <= x_in;
      a_col <= in_col;
      // forward a same-address write that lands on this edge
      if (b_go && (a_col == in_col)) begin
        a_top <= a_mid;
      end else begin
        a_top <= upper_line[in_col];
      end
    end
    if (b_go) begin
      upper_line[a_col] <= a_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff    <= WW'(W_RST);
      height_eff   <= HW'(H_RST);
      in_row       <= '0;
      in_col       <= '0;
      a_valid      <= 1'b0;
      a_res        <= 1'b0;
      out_row      <= '0;
      out_col      <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        col_a[i] <= bbs_pkg::CELL_DEAD;
        col_b[i] <= bbs_pkg::CELL_DEAD;
      end
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        a_res   <= beat_res;
        if (beat_last) begin
          in_row <= '0;
          in_col <= '0;
        end else if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + IRW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end else if (b_go) begin
        a_valid <= 1'b0;
      end

      if (b_go) begin
        if (a_res && last_b) begin
          for (int i = 0; i < 3; i++) begin
            col_a[i] <= bbs_pkg::CELL_DEAD;
            col_b[i] <= bbs_pkg::CELL_DEAD;
          end
          out_row <= '0;
          out_col <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            col_a[i] <= col_b[i];
            col_b[i] <= right[i];
          end
          if (a_res) begin
            if (out_wrap) begin
              out_col <= '0;
              out_row <= out_row + ORW'(1);
            end else begin
              out_col <= out_col + CW'(1);
            end
          end
        end
      end

      if (b_go && a_res) begin
        result_valid         <= 1'b1;
        result.next_state    <= state_next;
        result.last_of_frame <= last_b;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      // any register write restarts the frame
      if (cfg_write) begin
        unique case (cfg_index)
          bbs_pkg::REG_GRID_WIDTH: begin
            width_eff <= WW'(clamp_dim(32'(cfg_data[bbs_pkg::WIDTH_REG_W-1:0]), MAX_WIDTH));
          end
          bbs_pkg::REG_GRID_HEIGHT: begin
            height_eff <= HW'(clamp_dim(32'(cfg_data[bbs_pkg::HEIGHT_REG_W-1:0]),
                                        MAX_HEIGHT));
          end
          default: begin
          end
        endcase
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        for (int i = 0; i < 3; i++) begin
          col_a[i] <= bbs_pkg::CELL_DEAD;
          col_b[i] <= bbs_pkg::CELL_DEAD;
        end
      end
    end
  end

endmodule

/* rtl/core/bbs_checker.sv */
// port-level assertions for the brian's brain stencil step unit, with its bind
module bbs_checker (
  input logic          clk,
  input logic          rst,
  input logic          cell_valid,
  input logic          cell_ready,
  input logic          result_valid,
  input logic          result_ready,
  input bbs_pkg::out_t result
);

  // a stalled result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // input only stalls behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !cell_ready |-> result_valid && !result_ready)
    else $error("cell_ready low without a stalled result");

  // a fresh result follows a cell transfer through the input stage
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cell_valid && cell_ready, 2))
    else $error("result appeared without a matching cell transfer");

  // no result ever carries the unused state code
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.next_state == bbs_pkg::CELL_DEAD ||
                      result.next_state == bbs_pkg::CELL_DYING ||
                      result.next_state == bbs_pkg::CELL_ALIVE))
    else $error("result carries an invalid state code");

endmodule

bind brians_brain_stencil_step_unit bbs_checker u_bbs_checker (.*);

/* verif/brians_brain_stencil_step_checker.sv */
// scoreboard for the brian's brain stencil step unit: predicts each next-state cell and checks it
`timescale 1ns / 100ps
module brians_brain_stencil_step_checker #(
  parameter int MAX_WIDTH  = bbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cell_valid,
  input  logic                            cell_ready,
  input  bbs_pkg::in_t                    cell_data,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  bbs_pkg::out_t                   result,
  input  logic                            cfg_write,
  input  logic [bbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              frames,
  output int                              births
);

  localparam int unsigned BIRTH_COUNT = 2;

  typedef struct {
    bbs_pkg::out_t res;
    int unsigned   row;
    int unsigned   col;
  } next_cell_t;

  logic [1:0]                       upper_row  [MAX_WIDTH];
  logic [1:0]                       middle_row [MAX_WIDTH];
  // 3x3 window, index col * 3 + row, col 0 left, row 0 top
  logic [1:0]                       win [9];
  logic [bbs_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [bbs_pkg::HEIGHT_REG_W-1:0] height_reg;
  int unsigned                      in_row, in_col, out_row, out_col;
  next_cell_t                       next_gen_q [$];

  function automatic int unsigned fit_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned alive_if(logic [1:0] v, bit ok);
    return (ok && v == bbs_pkg::CELL_ALIVE) ? 1 : 0;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic clear_raster();
    foreach (win[k]) win[k] = bbs_pkg::CELL_DEAD;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  task automatic advance_stencil(bbs_pkg::in_t c);
    int unsigned w, h, col, n;
    logic [1:0]  x, top, mid, nxt;
    bit          l, r, t, b, produce;
    next_cell_t  p;
    w = fit_dim(32'(width_reg), MAX_WIDTH);
    h = fit_dim(32'(height_reg), MAX_HEIGHT);
    x = c.flush ? bbs_pkg::CELL_DEAD : c.cell_state;
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    top = upper_row[col];
    mid = middle_row[col];
    upper_row[col] = mid;
    middle_row[col] = x;
    for (int k = 0; k < 6; k++) win[k] = win[k + 3];
    win[6] = top;
    win[7] = mid;
    win[8] = x;
    // output trails the input by one row and one cell
    produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!produce) return;
    // neighbors outside the grid count as dead
    l = out_col > 0;
    r = out_col + 1 < w;
    t = out_row > 0;
    b = out_row + 1 < h;
    n = alive_if(win[0], l && t) + alive_if(win[3], t) + alive_if(win[6], r && t)
      + alive_if(win[1], l) + alive_if(win[7], r)
      + alive_if(win[2], l && b) + alive_if(win[5], b) + alive_if(win[8], r && b);
    case (win[4])
      bbs_pkg::CELL_ALIVE: nxt = bbs_pkg::CELL_DYING;
      bbs_pkg::CELL_DYING: nxt = bbs_pkg::CELL_DEAD;
      bbs_pkg::CELL_DEAD:  nxt = (n == BIRTH_COUNT) ? bbs_pkg::CELL_ALIVE : bbs_pkg::CELL_DEAD;
      default:             nxt = bbs_pkg::CELL_DEAD;
    endcase
    if (win[4] == bbs_pkg::CELL_DEAD && n == BIRTH_COUNT) births++;
    p.res.next_state = nxt;
    p.res.last_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
    p.row = out_row;
    p.col = out_col;
    next_gen_q.push_back(p);
    if (p.res.last_of_frame) begin
      clear_raster();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  initial begin
    foreach (upper_row[i]) upper_row[i] = bbs_pkg::CELL_DEAD;
    foreach (middle_row[i]) middle_row[i] = bbs_pkg::CELL_DEAD;
    width_reg = bbs_pkg::WIDTH_REG_W'(bbs_pkg::GRID_WIDTH_RESET);
    height_reg = bbs_pkg::HEIGHT_REG_W'(bbs_pkg::GRID_HEIGHT_RESET);
    clear_raster();
    errors = 0;
    pending = 0;
    frames = 0;
    births = 0;
  end

  always @(posedge clk) begin : watch
    next_cell_t want;
    if (rst) begin
      // line buffers keep their contents across reset
      width_reg = bbs_pkg::WIDTH_REG_W'(bbs_pkg::GRID_WIDTH_RESET);
      height_reg = bbs_pkg::HEIGHT_REG_W'(bbs_pkg::GRID_HEIGHT_RESET);
      clear_raster();
      next_gen_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == bbs_pkg::REG_GRID_WIDTH)
          width_reg = cfg_data[bbs_pkg::WIDTH_REG_W-1:0];
        else if (cfg_index == bbs_pkg::REG_GRID_HEIGHT)
          height_reg = cfg_data[bbs_pkg::HEIGHT_REG_W-1:0];
        clear_raster();
      end
      if (cell_valid && cell_ready) advance_stencil(cell_data);
      if (result_valid && result_ready) begin
        if (next_gen_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: state %0d last %0b",
                                    result.next_state, result.last_of_frame));
        end else begin
          want = next_gen_q.pop_front();
          if (result.next_state !== want.res.next_state)
            report_mismatch($sformatf("next_state at row %0d col %0d: got %0d want %0d",
                                      want.row, want.col, result.next_state,
                                      want.res.next_state));
          if (result.last_of_frame !== want.res.last_of_frame)
            report_mismatch($sformatf("last_of_frame at row %0d col %0d: got %0b want %0b",
                                      want.row, want.col, result.last_of_frame,
                                      want.res.last_of_frame));
          if (want.res.last_of_frame) frames++;
        end
      end
    end
    pending = next_gen_q.size();
  end

endmodule

/* verif/brians_brain_stencil_step_unit_test.sv */
// top of the stencil step unit regression: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module brians_brain_stencil_step_unit_test;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_CELLS  = 1000;
  localparam logic [1:0] CELL_BAD = 2'd3;  // illegal encoding, must act as dead

  logic                            clk;
  logic                            rst;
  logic                            cell_valid;
  logic                            cell_ready;
  bbs_pkg::in_t                    cell_data;
  logic                            result_valid;
  logic                            result_ready;
  bbs_pkg::out_t                   result;
  logic                            cfg_write;
  logic [bbs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data;

  int          errors, pending, frames, births;
  int          cells_sent, grid_writes;
  int unsigned grid_w, grid_h;
  bit          steady;
  bit          hold_req;

  brians_brain_stencil_step_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  brians_brain_stencil_step_checker grid_check (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .frames       (frames),
    .births       (births)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned grid_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [1:0] pick_cell(int unsigned alive_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return CELL_BAD;
    if (r < 2 + alive_pct) return bbs_pkg::CELL_ALIVE;
    if (r < 17 + alive_pct) return bbs_pkg::CELL_DYING;
    return bbs_pkg::CELL_DEAD;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic put_cell(logic [1:0] st, logic pad);
    if (!steady && $urandom_range(99) < 10) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cell_valid <= 1'b1;
    cell_data <= '{cell_state: st, flush: pad};
    do @(posedge clk); while (!cell_ready);
    @(negedge clk);
    cells_sent++;
  endtask

  // registers only change once the pipeline has drained
  task automatic set_grid(int unsigned w_raw, int unsigned h_raw);
    cell_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= bbs_pkg::REG_GRID_WIDTH;
    cfg_data <= w_raw[bbs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= bbs_pkg::REG_GRID_HEIGHT;
    cfg_data <= h_raw[bbs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    grid_w = grid_dim(w_raw, bbs_pkg::MAX_WIDTH_DEF);
    grid_h = grid_dim(h_raw, bbs_pkg::MAX_HEIGHT_DEF);
    grid_writes++;
  endtask

  // grid cells first, then the flush tail; fewer beats cut the frame short
  task automatic send_frame(int unsigned alive_pct, int unsigned beats);
    int unsigned cells;
    cells = grid_w * grid_h;
    for (int unsigned i = 0; i < beats; i++) begin
      if (i < cells) put_cell(pick_cell(alive_pct), $urandom_range(99) < 3);
      else put_cell(pick_cell(alive_pct), $urandom_range(9) != 0);
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || $urandom_range(99) >= 20;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cell_valid && cell_ready) || (result_valid && result_ready) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("brians_brain_stencil_step_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_goal, w_raw, h_raw, alive_pct;
    rst = 1'b1;
    cell_valid = 1'b0;
    cell_data = '0;
    cfg_write = 1'b0;
    cfg_index = bbs_pkg::REG_GRID_WIDTH;
    cfg_data = '0;
    cells_sent = 0;
    grid_writes = 0;
    grid_w = bbs_pkg::GRID_WIDTH_RESET;
    grid_h = bbs_pkg::GRID_HEIGHT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 3x3 frame: birth in the center with an illegal cell and a flushed alive
    // cell among its neighbors, plus a live beat in the flush tail
    set_grid(3, 3);
    put_cell(bbs_pkg::CELL_ALIVE, 1'b0);
    put_cell(bbs_pkg::CELL_DEAD, 1'b0);
    put_cell(bbs_pkg::CELL_ALIVE, 1'b0);
    put_cell(bbs_pkg::CELL_DYING, 1'b0);
    put_cell(bbs_pkg::CELL_DEAD, 1'b0);
    put_cell(bbs_pkg::CELL_DEAD, 1'b0);
    put_cell(CELL_BAD, 1'b0);
    put_cell(bbs_pkg::CELL_ALIVE, 1'b1);
    put_cell(bbs_pkg::CELL_DEAD, 1'b0);
    put_cell(bbs_pkg::CELL_DEAD, 1'b1);
    put_cell(CELL_BAD, 1'b1);
    put_cell(bbs_pkg::CELL_ALIVE, 1'b0);
    put_cell(bbs_pkg::CELL_DEAD, 1'b1);

    random_goal = cells_sent + RANDOM_CELLS;
    for (int p = 0; cells_sent < random_goal; p++) begin
      steady = (p == 0 || p == 3);
      w_raw = ($urandom_range(99) < 10) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_raw = ($urandom_range(99) < 10) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      alive_pct = $urandom_range(10, 60);
      set_grid(w_raw, h_raw);
      // receiver stalls long while cells keep coming
      if (p == 0) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) send_frame(alive_pct, grid_w * grid_h + grid_w + 1);
      if ($urandom_range(99) < 20) send_frame(alive_pct, $urandom_range(1, grid_w * grid_h));
    end
    steady = 1'b0;

    cell_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run covered %0d cell transfers over %0d grid sizes, %0d frames closed, %0d births",
             cells_sent, grid_writes, frames, births);
    if (errors == 0) begin
      $display("brians_brain_stencil_step_unit regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("brians_brain_stencil_step_unit regression: fail");
    end
    $finish;
  end

endmodule
